// ===== hw/rtl/fault_tree_monte_carlo_trial_macros.svh =====
// Assertion macros for the fault tree trial engine.
// Used by the top level only; no other dependencies.
`ifndef FAULT_TREE_MONTE_CARLO_TRIAL_MACROS_SVH
`define FAULT_TREE_MONTE_CARLO_TRIAL_MACROS_SVH
// assert that a implies b on the next clock
`define FTMC_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
// assert that a implies b in the same clock
`define FTMC_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/ftmc_pkg.sv =====
// Shared types and constants for the fault tree trial engine.
// No dependencies.
package ftmc_pkg;
  localparam int MaxNodes  = 256;
  localparam int MaxBasic  = 128;
  localparam int EdgeDepth = 1024;
  localparam int MaxFanin  = 255;
  localparam logic [31:0] DefaultSeed = 32'd981;

  localparam logic [1:0] ACT_PROB  = 2'd0;
  localparam logic [1:0] ACT_NODE  = 2'd1;
  localparam logic [1:0] ACT_EDGE  = 2'd2;
  localparam logic [1:0] ACT_TRIAL = 2'd3;

  localparam logic [2:0] KIND_OR  = 3'd1;
  localparam logic [2:0] KIND_AND = 3'd2;
  localparam logic [2:0] KIND_NOT = 3'd3;
  localparam logic [2:0] KIND_KN  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_KERR  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [1:0] REG_NODES = 2'd0;
  localparam logic [1:0] REG_BASIC = 2'd1;
  localparam logic [1:0] REG_SEED  = 2'd2;

  // node record: kind, k, first edge, edge count
  localparam int NodeW = 29;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  slot;
    logic [15:0] probability;
    logic [2:0]  gate_kind;
    logic [7:0]  threshold_k;
    logic [9:0]  first_edge;
    logic [7:0]  edge_count;
    logic [7:0]  child_node;
  } req_t;

  typedef struct packed {
    logic        top_event;
    logic [31:0] hit_count;
    logic [31:0] trial_count;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WR, S_DRAW_RD, S_DRAW_WR, S_NODE_RD, S_NODE_WT, S_EDGE_RD,
    S_EDGE_WT, S_STATE_WT, S_NODE_WR, S_TOP_RD, S_TOP_WT, S_DONE
  } state_t;

  function automatic logic [31:0] xs32(input logic [31:0] v);
    logic [31:0] x;
    x = v ^ (v << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction
endpackage

// ===== hw/rtl/fault_tree_monte_carlo_trial.sv =====
// Fault tree Monte Carlo trial engine: one request loads a table entry or
// runs one trial, and returns one result with the running counters.
// A load passes through write, result and idle from acceptance to the next
// acceptance. A trial's length is set by the single read port of each table
// RAM (probabilities, nodes, edges, node states); an OR/AND stops at its first
// deciding child. A stalled result holds the engine in its result state.
// Tables are undefined until written.
module fault_tree_monte_carlo_trial (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ftmc_pkg::req_t        in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ftmc_pkg::rsp_t        out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import ftmc_pkg::*;
  `include "fault_tree_monte_carlo_trial_macros.svh"

  state_t state, state_next;
  req_t   req;
  logic [8:0]  used_nodes;
  logic [7:0]  used_basic;
  logic [31:0] gen, hits, trials;
  logic [8:0]  nodes_c, node;
  logic [7:0]  basic_c, cnt, lidx;
  logic        s_acc, fault, top_r;
  logic [1:0]  status_r;
  logic        busy;

  always_comb begin
    nodes_c = used_nodes;
    if (used_nodes < 9'd2) nodes_c = 9'd2;
    if (used_nodes > 9'(MaxNodes)) nodes_c = 9'(MaxNodes);
    basic_c = (used_basic == 8'd0) ? 8'd1 : used_basic;
    if ({1'b0, basic_c} > 9'(MaxBasic)) basic_c = 8'(MaxBasic);
  end

  // memories
  logic [15:0] prob_rd;
  logic [NodeW-1:0] node_rd;
  logic [7:0]  edge_rd;
  logic        st_rd;
  logic        prob_we, node_we, edge_we, st_we;
  logic [6:0]  prob_ra;
  logic [7:0]  node_ra, st_ra, st_wa;
  logic [9:0]  edge_ra;
  logic        st_wd;

  ftmc_ram #(.Width(16), .Depth(MaxBasic)) u_prob (
    .clk, .we(prob_we), .waddr(req.slot[6:0]), .wdata(req.probability),
    .raddr(prob_ra), .rdata(prob_rd));
  ftmc_ram #(.Width(NodeW), .Depth(MaxNodes)) u_node (
    .clk, .we(node_we), .waddr(req.slot[7:0]),
    .wdata({req.gate_kind, req.threshold_k, req.first_edge, req.edge_count}),
    .raddr(node_ra), .rdata(node_rd));
  ftmc_ram #(.Width(8), .Depth(EdgeDepth)) u_edge (
    .clk, .we(edge_we), .waddr(req.slot), .wdata(req.child_node),
    .raddr(edge_ra), .rdata(edge_rd));
  ftmc_ram #(.Width(1), .Depth(MaxNodes)) u_st (
    .clk, .we(st_we), .waddr(st_wa), .wdata(st_wd),
    .raddr(st_ra), .rdata(st_rd));

  logic [2:0] kind;
  logic [7:0] kthr, ecnt;
  logic [9:0] fedge;
  assign {kind, kthr, fedge, ecnt} = node_rd;
  logic [31:0] gnext;
  assign gnext = xs32(gen);

  // read addresses
  assign prob_ra = node[6:0];
  assign node_ra = node[7:0];
  assign edge_ra = fedge + {2'b0, lidx};
  assign st_ra   = (state == S_TOP_RD) ? 8'(nodes_c - 9'd1) : edge_rd;

  // number of edges to visit for current gate
  logic [7:0] nvisit;
  always_comb begin
    nvisit = (ecnt > 8'(MaxFanin)) ? 8'(MaxFanin) : ecnt;
    if (kind == KIND_NOT) nvisit = 8'd1;
  end
  logic gate_has_edges;
  assign gate_has_edges = (kind == KIND_OR || kind == KIND_AND || kind == KIND_NOT ||
                           (kind == KIND_KN && kthr <= nvisit)) && nvisit != 8'd0;

  logic decided;
  always_comb begin
    decided = 1'b0;
    if (kind == KIND_OR && st_rd) decided = 1'b1;
    if (kind == KIND_AND && !st_rd) decided = 1'b1;
  end

  logic gate_val;
  always_comb begin
    unique case (kind)
      KIND_OR:  gate_val = s_acc;
      KIND_AND: gate_val = s_acc;
      KIND_NOT: gate_val = s_acc;
      KIND_KN:  gate_val = (kthr <= nvisit) && (cnt >= kthr);
      default:  gate_val = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = (in_data.action == ACT_TRIAL) ? S_DRAW_RD : S_WR;
      S_WR: state_next = S_DONE;
      S_DRAW_RD: state_next = S_DRAW_WR;
      S_DRAW_WR: state_next = ({1'b0, node[7:0]} + 9'd1 >= {1'b0, basic_c})
                              ? ((node + 9'd1 >= nodes_c) ? S_TOP_RD : S_NODE_RD)
                              : S_DRAW_RD;
      S_NODE_RD: state_next = S_NODE_WT;
      S_NODE_WT: state_next = gate_has_edges ? S_EDGE_RD : S_NODE_WR;
      S_EDGE_RD: state_next = S_EDGE_WT;
      S_EDGE_WT: state_next = S_STATE_WT;
      S_STATE_WT: state_next = (decided || lidx + 8'd1 >= nvisit) ? S_NODE_WR : S_EDGE_RD;
      S_NODE_WR: state_next = (node + 9'd1 >= nodes_c) ? S_TOP_RD : S_NODE_RD;
      S_TOP_RD: state_next = S_TOP_WT;
      S_TOP_WT: state_next = S_DONE;
      S_DONE: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    prob_we = 1'b0; node_we = 1'b0; edge_we = 1'b0;
    st_we = 1'b0; st_wa = node[7:0]; st_wd = 1'b0;
    if (state == S_WR) begin
      prob_we = req.action == ACT_PROB && req.slot < 10'(MaxBasic);
      node_we = req.action == ACT_NODE && req.slot < 10'(MaxNodes);
      edge_we = req.action == ACT_EDGE;
    end
    // gen already holds this event's draw
    if (state == S_DRAW_WR && node < nodes_c) begin
      st_we = 1'b1;
      st_wd = ({1'b0, gen[31:16]} + {1'b0, prob_rd}) > 17'd65535;
    end
    if (state == S_NODE_WR) begin
      st_we = 1'b1;
      st_wd = gate_val;
    end
  end

  assign busy      = state != S_IDLE;
  assign in_stall  = busy;
  assign out_valid = state == S_DONE;
  assign out_data  = '{top_event: top_r, hit_count: hits,
                       trial_count: trials, status: status_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used_nodes <= 9'd256;
      used_basic <= 8'd128;
      gen <= DefaultSeed;
      hits <= '0;
      trials <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NODES: used_nodes <= cfg_data[8:0];
          REG_BASIC: used_basic <= cfg_data[7:0];
          REG_SEED:  gen <= (cfg_data == '0) ? DefaultSeed : cfg_data;
          default: ;
        endcase
      end
      if (state == S_DRAW_RD) gen <= gnext;
      if (state == S_TOP_WT && !fault) begin
        if (trials != '1) trials <= trials + 32'd1;
        if (st_rd && hits != '1) hits <= hits + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (in_valid) begin
        req <= in_data;
        node <= '0;
        fault <= 1'b0;
        top_r <= 1'b0;
        status_r <= ST_OK;
      end
      S_WR: begin
        if ((req.action == ACT_PROB && req.slot >= 10'(MaxBasic)) ||
            (req.action == ACT_NODE && req.slot >= 10'(MaxNodes)))
          status_r <= ST_RANGE;
      end
      S_DRAW_WR: node <= node + 9'd1;
      S_NODE_WT: begin
        lidx <= '0;
        cnt <= '0;
        s_acc <= (kind == KIND_AND);
        if (kind == KIND_KN && kthr > nvisit) fault <= 1'b1;
      end
      S_STATE_WT: begin
        lidx <= lidx + 8'd1;
        if (st_rd) cnt <= cnt + 8'd1;
        if (kind == KIND_OR && st_rd) s_acc <= 1'b1;
        if (kind == KIND_AND && !st_rd) s_acc <= 1'b0;
        if (kind == KIND_NOT) s_acc <= !st_rd;
      end
      S_NODE_WR: node <= node + 9'd1;
      S_TOP_WT: begin
        top_r <= !fault && st_rd;
        status_r <= fault ? ST_KERR : ST_OK;
      end
      default: ;
    endcase
  end

  `FTMC_ASSERT_NOW(a_out_only_idle_free, out_valid, in_stall)
  `FTMC_ASSERT_NEXT(a_kerr_no_top, state == S_TOP_WT && fault,
                    !out_data.top_event && out_data.status == ST_KERR)
  `FTMC_ASSERT_NEXT(a_trials_mono, state != S_TOP_WT && !cfg_we,
                    trials == $past(trials))
endmodule

// ===== hw/rtl/ftmc_ram.sv =====
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module ftmc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== bench/fault_tree_monte_carlo_trial_tb.sv =====
// Testbench for fault_tree_monte_carlo_trial: loads fault tree tables and runs
// trials against an in-bench predictor, checking every result.
// Depends on ftmc_pkg and the fault_tree_monte_carlo_trial RTL.
`timescale 1ns / 1ps
module fault_tree_monte_carlo_trial_tb;
  import ftmc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_NODES;
  logic [31:0] cfg_data = '0;

  fault_tree_monte_carlo_trial uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // tree mirror
  bit [15:0] prob_tbl [MaxBasic];
  bit [2:0]  kind_tbl [MaxNodes];
  bit [7:0]  k_tbl    [MaxNodes];
  bit [9:0]  fe_tbl   [MaxNodes];
  bit [7:0]  cnt_tbl  [MaxNodes];
  bit [7:0]  edge_tbl [EdgeDepth];
  bit        node_val [MaxNodes];
  bit [31:0] lfsr_val = DefaultSeed;
  bit [31:0] hit_tally = 0;
  bit [31:0] trial_tally = 0;
  bit [8:0]  nodes_reg = 9'd256;
  bit [7:0]  basic_reg = 8'd128;

  // loaded tree: nodes and probabilities below TreeNodes, one edge window
  localparam int TreeNodes = 64;
  localparam int EdgeBase  = 992;
  localparam int EdgeWin   = 32;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int send_idle = 19;
  int recv_stall = 64;
  int errors = 0;
  int quiet_cycles = 0;
  localparam int WatchdogLimit = 400000;

  initial forever #6 clk = ~clk;

  function automatic bit child_val(int nd, int l);
    return node_val[edge_tbl[(fe_tbl[nd] + l) % EdgeDepth]];
  endfunction

  function automatic rsp_t evaluate_request(req_t r);
    rsp_t o;
    int nodes, basic, n, cnt;
    bit s, fault;
    bit [31:0] x;
    o = '0;
    fault = 0;
    case (r.action)
      ACT_PROB: if (r.slot < MaxBasic) prob_tbl[r.slot] = r.probability;
                else o.status = ST_RANGE;
      ACT_NODE: if (r.slot < MaxNodes) begin
        kind_tbl[r.slot] = r.gate_kind;
        k_tbl[r.slot] = r.threshold_k;
        fe_tbl[r.slot] = r.first_edge;
        cnt_tbl[r.slot] = r.edge_count;
      end else o.status = ST_RANGE;
      ACT_EDGE: edge_tbl[r.slot] = r.child_node;
      default: begin
        nodes = nodes_reg;
        basic = basic_reg;
        if (nodes < 2) nodes = 2;
        if (nodes > MaxNodes) nodes = MaxNodes;
        if (basic < 1) basic = 1;
        if (basic > MaxBasic) basic = MaxBasic;
        for (int j = 0; j < basic; j++) begin
          x = lfsr_val;
          x ^= x << 13;
          x ^= x >> 17;
          x ^= x << 5;
          lfsr_val = x;
          if (j < nodes) node_val[j] = ({16'd0, x[31:16]} + prob_tbl[j]) > 65535;
        end
        for (int k = basic; k < nodes; k++) begin
          n = cnt_tbl[k];
          s = 0;
          if (kind_tbl[k] == KIND_OR) begin
            for (int l = 0; l < n && !s; l++) if (child_val(k, l)) s = 1;
          end else if (kind_tbl[k] == KIND_AND) begin
            s = 1;
            for (int l = 0; l < n && s; l++) if (!child_val(k, l)) s = 0;
          end else if (kind_tbl[k] == KIND_NOT) begin
            s = !child_val(k, 0);
          end else if (kind_tbl[k] == KIND_KN) begin
            if (k_tbl[k] > n) fault = 1;
            else begin
              cnt = 0;
              for (int l = 0; l < n; l++) if (child_val(k, l)) cnt++;
              s = cnt >= k_tbl[k];
            end
          end
          node_val[k] = s;
        end
        if (fault) o.status = ST_KERR;
        else begin
          o.top_event = node_val[nodes - 1];
          if (trial_tally != 32'hFFFFFFFF) trial_tally++;
          if (o.top_event && hit_tally != 32'hFFFFFFFF) hit_tally++;
        end
      end
    endcase
    o.hit_count = hit_tally;
    o.trial_count = trial_tally;
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_rsps.push_back(evaluate_request(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("TB_ERROR");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t unexpected result %h", $time, out_data);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (e.top_event !== out_data.top_event) begin
            $display("%0t top_event exp %0d got %0d", $time, e.top_event, out_data.top_event);
            errors++;
          end
          if (e.hit_count !== out_data.hit_count) begin
            $display("%0t hit_count exp %0d got %0d", $time, e.hit_count, out_data.hit_count);
            errors++;
          end
          if (e.trial_count !== out_data.trial_count) begin
            $display("%0t trial_count exp %0d got %0d", $time, e.trial_count,
                     out_data.trial_count);
            errors++;
          end
          if (e.status !== out_data.status) begin
            $display("%0t status exp %0d got %0d", $time, e.status, out_data.status);
            errors++;
          end
        end
      end
    end
  end

  function automatic req_t rand_req();
    logic [95:0] w;
    w = {$urandom, $urandom, $urandom};
    return w[$bits(req_t)-1:0];
  endfunction

  function automatic req_t trial_req();
    req_t r;
    r = rand_req();
    r.action = ACT_TRIAL;
    return r;
  endfunction

  function automatic req_t prob_req(int slot, int p);
    req_t r;
    r = rand_req();
    r.action = ACT_PROB;
    r.slot = 10'(slot);
    r.probability = 16'(p);
    return r;
  endfunction

  function automatic req_t edge_req(int slot, int child);
    req_t r;
    r = rand_req();
    r.action = ACT_EDGE;
    r.slot = 10'(slot);
    r.child_node = 8'(child);
    return r;
  endfunction

  // the edge window is always loaded; runs stay inside it
  function automatic req_t gate_req(int slot, bit kerr);
    req_t r;
    int n, pick, v;
    r = rand_req();
    r.action = ACT_NODE;
    r.slot = 10'(slot);
    n = ($urandom_range(15) == 0) ? $urandom_range(7, EdgeWin - 1) : $urandom_range(0, 6);
    pick = $urandom_range(9);
    if (kerr) r.gate_kind = KIND_KN;
    else if (pick < 3) r.gate_kind = KIND_OR;
    else if (pick < 5) r.gate_kind = KIND_AND;
    else if (pick == 5) r.gate_kind = KIND_NOT;
    else if (pick < 9) r.gate_kind = KIND_KN;
    else begin
      v = $urandom_range(3);
      r.gate_kind = (v == 0) ? 3'd0 : 3'(v + 4);
    end
    r.edge_count = 8'(n);
    r.first_edge = 10'(EdgeBase + $urandom_range(0, EdgeWin - 1 - n));
    if (kerr) r.threshold_k = 8'($urandom_range(n + 1, 255));
    else if (r.gate_kind == KIND_KN) r.threshold_k = 8'($urandom_range(0, n));
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NODES: nodes_reg = v[8:0];
      REG_BASIC: basic_reg = v[7:0];
      default:   lfsr_val = (v == 0) ? DefaultSeed : v;
    endcase
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int r, s;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 50) pending_reqs.push_back(trial_req());
      else if (r < 63) begin
        s = ($urandom_range(9) == 0) ? $urandom_range(MaxBasic, 1023) : $urandom_range(0, 127);
        pending_reqs.push_back(prob_req(s, $urandom_range(0, 65535)));
      end else if (r < 83) begin
        s = ($urandom_range(9) == 0) ? $urandom_range(MaxNodes, 1023) : $urandom_range(0, 255);
        pending_reqs.push_back(gate_req(s, 1'b0));
      end else if (r < 97) begin
        pending_reqs.push_back(edge_req($urandom_range(0, 1023),
                                        $urandom_range(0, TreeNodes - 1)));
      end else begin
        // bad k-of-n, one trial, then repaired
        s = $urandom_range(2, 255);
        pending_reqs.push_back(gate_req(s, 1'b1));
        pending_reqs.push_back(trial_req());
        pending_reqs.push_back(gate_req(s, 1'b0));
      end
    end
    drain();
  endtask

  initial begin
    req_t g;
    int nodes;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // table load; first trial evaluates every loaded node, children all basic
    write_reg(REG_NODES, TreeNodes);
    write_reg(REG_BASIC, 32);
    for (int i = 0; i < TreeNodes; i++)
      pending_reqs.push_back(prob_req(i, $urandom_range(0, 65535)));
    for (int i = 0; i < TreeNodes; i++) pending_reqs.push_back(gate_req(i, 1'b0));
    for (int i = 0; i < EdgeWin; i++)
      pending_reqs.push_back(edge_req(EdgeBase + i, $urandom_range(0, 31)));
    pending_reqs.push_back(trial_req());
    drain();

    // directed
    pending_reqs.push_back(prob_req(MaxBasic, 16'h1234));
    pending_reqs.push_back(prob_req(1023, 16'hFFFF));
    pending_reqs.push_back(gate_req(MaxNodes, 1'b0));
    pending_reqs.push_back(gate_req(1023, 1'b0));
    pending_reqs.push_back(prob_req(0, 0));
    pending_reqs.push_back(prob_req(127, 65535));
    pending_reqs.push_back(edge_req(EdgeBase, TreeNodes - 1));
    pending_reqs.push_back(edge_req(EdgeBase + 1, 0));
    for (int v = 0; v < 8; v++) begin
      g = gate_req(TreeNodes - 1, 1'b0);
      g.gate_kind = 3'(v);
      g.first_edge = 10'(EdgeBase);
      g.edge_count = (v == KIND_NOT) ? 8'd0 : 8'd2;
      g.threshold_k = (v == KIND_KN) ? 8'd0 : 8'hFF;
      pending_reqs.push_back(g);
      pending_reqs.push_back(trial_req());
    end
    pending_reqs.push_back(gate_req(TreeNodes - 1, 1'b1));
    pending_reqs.push_back(trial_req());
    pending_reqs.push_back(gate_req(TreeNodes - 1, 1'b0));
    pending_reqs.push_back(trial_req());
    drain();

    write_reg(REG_NODES, 0);
    write_reg(REG_BASIC, 0);
    write_reg(REG_SEED, 0);
    random_phase(25);
    write_reg(REG_NODES, TreeNodes);
    write_reg(REG_BASIC, TreeNodes);
    write_reg(REG_SEED, 32'hFFFFFFFF);
    random_phase(10);
    write_reg(REG_NODES, 12);
    write_reg(REG_BASIC, 40);
    random_phase(25);
    send_idle = 64;
    recv_stall = 19;
    write_reg(REG_NODES, 24);
    write_reg(REG_BASIC, 6);
    write_reg(REG_SEED, $urandom_range(1, 32'hFFFF_FFFF));
    random_phase(25);
    write_reg(REG_NODES, 64);
    write_reg(REG_BASIC, 16);
    random_phase(25);
    write_reg(REG_NODES, 63);
    write_reg(REG_BASIC, 31);
    random_phase(15);
    send_idle = 0;
    recv_stall = 0;
    for (int p = 0; p < 3; p++) begin
      nodes = $urandom_range(2, 60);
      write_reg(REG_NODES, nodes);
      write_reg(REG_BASIC, $urandom_range(1, nodes + 4));
      write_reg(REG_SEED, $urandom_range(1, 32'hFFFF_FFFF));
      random_phase(22);
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
